// ----- hdl/rope_pkg.sv -----
// shared types and constants for the rotary position embedding block
package rope_pkg;

    localparam int DATA_W  = 16;
    localparam int POS_W   = 9;
    localparam int IDX_W   = 7;
    localparam int HDIM_W  = 8;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int FRAC_SH = 14;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_APPLY = 1'b1;

    localparam logic [HDIM_W-1:0] HDIM_RESET = 8'd128;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        data_t cos_v;
        data_t sin_v;
    } entry_t;

    typedef struct packed {
        logic mul_en;
        logic out_en;
        logic clear;
    } lane_ctrl_t;

endpackage

// ----- hdl/rope_table.sv -----
// cos/sin table: one write port, two registered read ports
module rope_table #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  rope_pkg::entry_t  wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output rope_pkg::entry_t  rd_data_a,
    output rope_pkg::entry_t  rd_data_b
);
    import rope_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- hdl/rope_lane.sv -----
// one rotated output: two products, sum, round to nearest and saturate
module rope_lane (
    input  logic                 aclk,
    input  rope_pkg::lane_ctrl_t ctrl,
    input  logic                 subtract,
    input  rope_pkg::data_t      x_a,
    input  rope_pkg::data_t      coef_a,
    input  rope_pkg::data_t      x_b,
    input  rope_pkg::data_t      coef_b,
    output rope_pkg::data_t      result,
    output logic                 sat
);
    import rope_pkg::*;

    localparam int SUM_W = PROD_W + 1;
    localparam int RND_W = SUM_W + 1;
    localparam int RES_W = RND_W - FRAC_SH;

    logic signed [PROD_W-1:0] p0_reg, p1_reg;
    logic signed [PROD_W-1:0] p0_next, p1_next;
    logic signed [SUM_W-1:0]  term0, term1, sum;
    logic signed [RND_W-1:0]  rnd;
    logic signed [RES_W-1:0]  r;
    logic                     over_hi, over_lo;
    data_t                    result_reg, result_next;
    logic                     sat_reg, sat_next;

    assign p0_next = x_a * coef_a;
    assign p1_next = x_b * coef_b;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
    end

    always_comb begin
        term0 = SUM_W'(p0_reg);
        term1 = subtract ? -SUM_W'(p1_reg) : SUM_W'(p1_reg);
        sum   = term0 + term1;
        // add half an lsb, then floor shift gives ties toward +inf
        rnd   = RND_W'(sum) + RND_W'(1 << (FRAC_SH - 1));
        r     = rnd[RND_W-1:FRAC_SH];
        over_hi = !r[RES_W-1] && (|r[RES_W-2:DATA_W-1]);
        over_lo = r[RES_W-1] && !(&r[RES_W-2:DATA_W-1]);
        if (ctrl.clear) begin
            result_next = '0;
            sat_next    = 1'b0;
        end else if (over_hi) begin
            result_next = {1'b0, {(DATA_W-1){1'b1}}};
            sat_next    = 1'b1;
        end else if (over_lo) begin
            result_next = {1'b1, {(DATA_W-1){1'b0}}};
            sat_next    = 1'b1;
        end else begin
            result_next = r[DATA_W-1:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_en) begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

// ----- hdl/rotary_position_embedding.sv -----
// rotary position embedding top level: checks, table access and output pipeline
// a result beat moves through va_reg, vb_reg and vc_reg, which drives m_valid
// throughput: one beat per cycle unless stalled; pair entries come from the two read ports
// table writes complete at the accept edge, so later reads see them at once
// reset clears pipeline valids and sets hd_reg to 128; table contents stay
// undefined until written and are never cleared
module rotary_position_embedding #(
    parameter int MAX_POSITIONS = 512,
    parameter int HEAD_DIM      = 128
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rope_pkg::HDIM_W-1:0]        cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [rope_pkg::POS_W-1:0]         s_position,
    input  logic [rope_pkg::IDX_W-1:0]         s_element_index,
    input  rope_pkg::data_t                    s_cos_value,
    input  rope_pkg::data_t                    s_sin_value,
    input  rope_pkg::data_t                    s_q_first,
    input  rope_pkg::data_t                    s_q_second,
    input  rope_pkg::data_t                    s_k_first,
    input  rope_pkg::data_t                    s_k_second,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rope_pkg::data_t                    m_q_first_out,
    output rope_pkg::data_t                    m_q_second_out,
    output rope_pkg::data_t                    m_k_first_out,
    output rope_pkg::data_t                    m_k_second_out,
    output logic                               m_saturated,
    output logic                               m_range_error
);
    import rope_pkg::*;

    localparam int DEPTH = MAX_POSITIONS * HEAD_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int HDW   = $clog2(HEAD_DIM + 1);
    localparam int CW    = (HDW > HDIM_W) ? HDW : HDIM_W;
    localparam int PCW   = $clog2(MAX_POSITIONS + 1) > POS_W ?
                           $clog2(MAX_POSITIONS + 1) : POS_W;
    localparam int PW    = POS_W + HDW;

    logic [HDIM_W-1:0] hd_reg, hd_next;
    logic [CW-1:0]     dim_even, eff_dim, half;
    logic              pos_bad, in_err, accept, tbl_we;
    logic [PW-1:0]     row_base;
    logic [AW-1:0]     addr_a, addr_b;

    logic adv_a, adv_b, adv_c;
    logic va_reg, va_next, vb_reg, vc_reg;
    logic err_a_reg, err_b_reg, err_c_reg;
    data_t q1_a_reg, q2_a_reg, k1_a_reg, k2_a_reg;

    entry_t     rd_a, rd_b;
    entry_t     wr_entry;
    lane_ctrl_t lane_ctrl;
    logic       sat_q1, sat_q2, sat_k1, sat_k2;

    // config register
    assign hd_next = cfg_wr_en ? cfg_wr_data : hd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hd_reg <= HDIM_RESET;
        end else begin
            hd_reg <= hd_next;
        end
    end

    // effective head dim: drop low bit, clamp to 2..HEAD_DIM
    always_comb begin
        dim_even = CW'({hd_reg[HDIM_W-1:1], 1'b0});
        if (dim_even < CW'(2)) begin
            eff_dim = CW'(2);
        end else if (dim_even > CW'(HEAD_DIM)) begin
            eff_dim = CW'(HEAD_DIM);
        end else begin
            eff_dim = dim_even;
        end
        half = eff_dim >> 1;
    end

    always_comb begin
        pos_bad = PCW'(s_position) >= PCW'(MAX_POSITIONS);
        if (s_func == FUNC_WRITE) begin
            in_err = pos_bad || (CW'(s_element_index) >= eff_dim);
        end else begin
            in_err = pos_bad || (CW'(s_element_index) >= half);
        end
    end

    assign row_base = PW'(s_position) * PW'(HEAD_DIM);
    assign addr_a   = AW'(row_base) + AW'(s_element_index);
    assign addr_b   = addr_a + AW'(half);

    // stall chain: each stage moves when empty or when its successor moves
    assign adv_c   = !vc_reg || m_ready;
    assign adv_b   = !vb_reg || adv_c;
    assign adv_a   = !va_reg || adv_b;
    assign s_ready = adv_a;

    assign accept  = s_valid && s_ready;
    assign tbl_we  = accept && (s_func == FUNC_WRITE) && !in_err;
    assign va_next = accept && ((s_func == FUNC_APPLY) || in_err);

    assign wr_entry.cos_v = s_cos_value;
    assign wr_entry.sin_v = s_sin_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (adv_a) begin
                va_reg <= va_next;
            end
            if (adv_b) begin
                vb_reg <= va_reg;
            end
            if (adv_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            err_a_reg <= in_err;
            q1_a_reg  <= s_q_first;
            q2_a_reg  <= s_q_second;
            k1_a_reg  <= s_k_first;
            k2_a_reg  <= s_k_second;
        end
        if (adv_b) begin
            err_b_reg <= err_a_reg;
        end
        if (adv_c) begin
            err_c_reg <= err_b_reg;
        end
    end

    rope_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (tbl_we),
        .wr_addr   (addr_a),
        .wr_data   (wr_entry),
        .rd_en     (adv_a),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign lane_ctrl.mul_en = adv_b;
    assign lane_ctrl.out_en = adv_c;
    assign lane_ctrl.clear  = err_b_reg;

    // first = x1*cos[j] - x2*sin[j], second = x2*cos[j+half] + x1*sin[j+half]
    rope_lane u_lane_q1 (
        .aclk (aclk), .ctrl (lane_ctrl), .subtract (1'b1),
        .x_a (q1_a_reg), .coef_a (rd_a.cos_v), .x_b (q2_a_reg), .coef_b (rd_a.sin_v),
        .result (m_q_first_out), .sat (sat_q1)
    );

    rope_lane u_lane_q2 (
        .aclk (aclk), .ctrl (lane_ctrl), .subtract (1'b0),
        .x_a (q2_a_reg), .coef_a (rd_b.cos_v), .x_b (q1_a_reg), .coef_b (rd_b.sin_v),
        .result (m_q_second_out), .sat (sat_q2)
    );

    rope_lane u_lane_k1 (
        .aclk (aclk), .ctrl (lane_ctrl), .subtract (1'b1),
        .x_a (k1_a_reg), .coef_a (rd_a.cos_v), .x_b (k2_a_reg), .coef_b (rd_a.sin_v),
        .result (m_k_first_out), .sat (sat_k1)
    );

    rope_lane u_lane_k2 (
        .aclk (aclk), .ctrl (lane_ctrl), .subtract (1'b0),
        .x_a (k2_a_reg), .coef_a (rd_b.cos_v), .x_b (k1_a_reg), .coef_b (rd_b.sin_v),
        .result (m_k_second_out), .sat (sat_k2)
    );

    assign m_valid       = vc_reg;
    assign m_range_error = err_c_reg;
    assign m_saturated   = sat_q1 || sat_q2 || sat_k1 || sat_k2;

    // a table write beat never enters the pipeline
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_we |=> !va_reg)
        else $error("table write beat entered the pipeline");

    // input side only stalls when every stage holds a beat
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (va_reg && vb_reg && vc_reg))
        else $error("input stalled with a free pipeline stage");

    // error results carry zero data and no saturation
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_range_error) |-> (m_q_first_out == '0 && m_q_second_out == '0 &&
            m_k_first_out == '0 && m_k_second_out == '0 && !m_saturated))
        else $error("range error result with nonzero data");

    // a beat in the middle stage reaches the output once the output is taken
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (vb_reg && m_valid && m_ready) |=> m_valid)
        else $error("beat lost between middle and output stage");

endmodule
